// File: src/svss_pkg.sv
`default_nettype none

package svss_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TIME_FRAC_BITS  = 8;

    localparam int TIME_W     = 22;
    localparam int ANGLE_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int ELAPSED_W  = 16;
    localparam int SPACING_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // Spacing is (time << ANGLE_FRAC_BITS) / (span << TIME_FRAC_BITS).
    localparam int NUM_W     = TIME_W + ANGLE_FRAC_BITS;
    localparam int DEN_W     = ANGLE_W + TIME_FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int HOLD_CMP_W = ELAPSED_W + TIME_FRAC_BITS;

    localparam logic [ANGLE_W-1:0]   ONE_DEG     = ANGLE_W'(1 << ANGLE_FRAC_BITS);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [SPACING_W-1:0] SPACING_MAX = {SPACING_W{1'b1}};

    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RISE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FALL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LOW  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd5;

    localparam logic [TIME_W-1:0]  RST_RISE_TIME = 22'd30845;
    localparam logic [TIME_W-1:0]  RST_FALL_TIME = 22'd30845;
    localparam logic [TIME_W-1:0]  RST_HOLD_HIGH = 22'd40710;
    localparam logic [TIME_W-1:0]  RST_HOLD_LOW  = 22'd183040;
    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE = 16'd5888;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE = 16'd21310;

    typedef struct packed {
        logic [TIME_W-1:0]  rise_time;
        logic [TIME_W-1:0]  fall_time;
        logic [TIME_W-1:0]  hold_high;
        logic [TIME_W-1:0]  hold_low;
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

// File: src/svss_cfg.sv
`default_nettype none

module svss_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [svss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [svss_pkg::CFG_DATA_W-1:0] cfg_data,
    output svss_pkg::cfg_t                       cfg
);

    svss_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_time <= svss_pkg::RST_RISE_TIME;
            cfg_reg.fall_time <= svss_pkg::RST_FALL_TIME;
            cfg_reg.hold_high <= svss_pkg::RST_HOLD_HIGH;
            cfg_reg.hold_low  <= svss_pkg::RST_HOLD_LOW;
            cfg_reg.min_angle <= svss_pkg::RST_MIN_ANGLE;
            cfg_reg.max_angle <= svss_pkg::RST_MAX_ANGLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svss_pkg::CFG_RISE_TIME: cfg_reg.rise_time <= cfg_data[svss_pkg::TIME_W-1:0];
                svss_pkg::CFG_FALL_TIME: cfg_reg.fall_time <= cfg_data[svss_pkg::TIME_W-1:0];
                svss_pkg::CFG_HOLD_HIGH: cfg_reg.hold_high <= cfg_data[svss_pkg::TIME_W-1:0];
                svss_pkg::CFG_HOLD_LOW:  cfg_reg.hold_low  <= cfg_data[svss_pkg::TIME_W-1:0];
                svss_pkg::CFG_MIN_ANGLE: cfg_reg.min_angle <= cfg_data[svss_pkg::ANGLE_W-1:0];
                svss_pkg::CFG_MAX_ANGLE: cfg_reg.max_angle <= cfg_data[svss_pkg::ANGLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/svss_div.sv
`default_nettype none

module svss_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire svss_pkg::div_req_t          req,
    output logic                             done,
    output logic [svss_pkg::NUM_W-1:0]       quotient
);

    localparam int NW = svss_pkg::NUM_W;
    localparam int DW = svss_pkg::DEN_W;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [svss_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [NW-1:0]                  quo_reg, quo_next;
    logic [DW-1:0]                  den_reg, den_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        fits;

    // Restoring division, one quotient bit per cycle, numerator shifted out MSB first.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = svss_pkg::DIV_CNT_W'(NW);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == svss_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/servo_sweep_sequencer_top.sv
`default_nettype none

// An accepted tick passes through ST_EXEC and ST_PUT before its result is registered; a tick
// that starts a rise or a fall sweep also passes ST_DIV, where the step spacing (Q8.8 angles)
// is computed. A new tick is taken only once the last one's result is registered; the serial
// divider for the step spacing works one quotient bit per cycle. A stalled result holds off the next.
// Reset (asynchronous, active low) clears the sequencer to idle with its internal angle and counters
// at zero and loads every configuration register with its default value.
module servo_sweep_sequencer_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [svss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [svss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            run_enable,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [svss_pkg::ANGLE_W-1:0]         angle,
    output logic [svss_pkg::PHASE_W-1:0]         phase
);

    typedef enum logic [3:0] {
        ST_READY = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_PUT   = 4'b1000
    } seq_state_t;

    localparam int AW = svss_pkg::ANGLE_W;

    svss_pkg::cfg_t     cfg;
    svss_pkg::div_req_t div_req;
    logic               div_done;
    logic [svss_pkg::NUM_W-1:0] div_quo;

    seq_state_t state_reg, state_next;
    logic run_reg, run_next;
    logic [svss_pkg::PHASE_W-1:0]   phase_st_reg, phase_st_next;
    logic [AW-1:0]                  cur_angle_reg, cur_angle_next;
    logic [svss_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [svss_pkg::SPACING_W-1:0] spacing_reg, spacing_next;
    logic                           out_valid_reg, out_valid_next;
    logic [AW-1:0]                  angle_reg, angle_next;
    logic [svss_pkg::PHASE_W-1:0]   phase_reg, phase_next;

    logic [svss_pkg::ELAPSED_W-1:0]  el_inc;
    logic [svss_pkg::HOLD_CMP_W-1:0] el_scaled;
    logic [AW-1:0]                   span_raw;
    logic [AW-1:0]                   span;
    logic [svss_pkg::TIME_W-1:0]     sweep_time;
    logic [AW:0]                     rise_next;
    logic [AW:0]                     fall_floor;
    logic                            out_free;

    svss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        el_inc     = (elapsed_reg != svss_pkg::ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        el_scaled  = {el_inc, {svss_pkg::TIME_FRAC_BITS{1'b0}}};
        span_raw   = (cfg.max_angle > cfg.min_angle) ? cfg.max_angle - cfg.min_angle : '0;
        span       = (span_raw < svss_pkg::ONE_DEG) ? svss_pkg::ONE_DEG : span_raw;
        sweep_time = (phase_st_reg == svss_pkg::PH_HIGH) ? cfg.fall_time : cfg.rise_time;
        rise_next  = {1'b0, cur_angle_reg} + {1'b0, svss_pkg::ONE_DEG};
        // Stepping down lands on the limit once current - 1 degree <= min.
        fall_floor = {1'b0, cfg.min_angle} + {1'b0, svss_pkg::ONE_DEG};
        out_free   = !out_valid_reg || !out_stall;

        div_req.start = 1'b0;
        div_req.num   = svss_pkg::NUM_W'(sweep_time) << svss_pkg::ANGLE_FRAC_BITS;
        div_req.den   = {span, {svss_pkg::TIME_FRAC_BITS{1'b0}}};

        state_next     = state_reg;
        run_next       = run_reg;
        phase_st_next  = phase_st_reg;
        cur_angle_next = cur_angle_reg;
        elapsed_next   = elapsed_reg;
        spacing_next   = spacing_reg;
        out_valid_next = out_valid_reg && out_stall;
        angle_next     = angle_reg;
        phase_next     = phase_reg;

        case (state_reg)
            ST_READY:
            begin
                if (in_valid)
                begin
                    run_next   = run_enable;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_PUT;
                if (!run_reg)
                begin
                    phase_st_next  = svss_pkg::PH_IDLE;
                    cur_angle_next = cfg.min_angle;
                end
                else
                begin
                    case (phase_st_reg)
                        svss_pkg::PH_RISE:
                        begin
                            elapsed_next = el_inc;
                            if (el_inc >= svss_pkg::ELAPSED_W'(spacing_reg))
                            begin
                                elapsed_next = '0;
                                if (rise_next >= {1'b0, cfg.max_angle})
                                begin
                                    cur_angle_next = cfg.max_angle;
                                    phase_st_next  = svss_pkg::PH_HIGH;
                                end
                                else
                                begin
                                    cur_angle_next = rise_next[AW-1:0];
                                end
                            end
                        end
                        svss_pkg::PH_HIGH:
                        begin
                            elapsed_next = el_inc;
                            if (el_scaled >= svss_pkg::HOLD_CMP_W'(cfg.hold_high))
                            begin
                                elapsed_next  = '0;
                                phase_st_next = svss_pkg::PH_FALL;
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        svss_pkg::PH_FALL:
                        begin
                            elapsed_next = el_inc;
                            if (el_inc >= svss_pkg::ELAPSED_W'(spacing_reg))
                            begin
                                elapsed_next = '0;
                                if ({1'b0, cur_angle_reg} <= fall_floor)
                                begin
                                    cur_angle_next = cfg.min_angle;
                                    phase_st_next  = svss_pkg::PH_LOW;
                                end
                                else
                                begin
                                    cur_angle_next = cur_angle_reg - svss_pkg::ONE_DEG;
                                end
                            end
                        end
                        svss_pkg::PH_LOW:
                        begin
                            elapsed_next = el_inc;
                            if (el_scaled >= svss_pkg::HOLD_CMP_W'(cfg.hold_low))
                            begin
                                elapsed_next  = '0;
                                phase_st_next = svss_pkg::PH_RISE;
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        default:
                        begin
                            // Idle, or a code that cannot arise: start a rise sweep.
                            cur_angle_next = cfg.min_angle;
                            elapsed_next   = '0;
                            phase_st_next  = svss_pkg::PH_RISE;
                            div_req.start  = 1'b1;
                            state_next     = ST_DIV;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    spacing_next = (div_quo > svss_pkg::NUM_W'(svss_pkg::SPACING_MAX))
                                 ? svss_pkg::SPACING_MAX
                                 : div_quo[svss_pkg::SPACING_W-1:0];
                    state_next   = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    angle_next     = cur_angle_reg;
                    phase_next     = phase_st_reg;
                    state_next     = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            run_reg       <= 1'b0;
            phase_st_reg  <= svss_pkg::PH_IDLE;
            cur_angle_reg <= '0;
            elapsed_reg   <= '0;
            spacing_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            phase_st_reg  <= phase_st_next;
            cur_angle_reg <= cur_angle_next;
            elapsed_reg   <= elapsed_next;
            spacing_reg   <= spacing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        phase_reg <= phase_next;
    end

    assign in_stall  = (state_reg != ST_READY);
    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;
    assign phase     = phase_reg;

endmodule

`default_nettype wire

// File: src/svss_checker.sv
`default_nettype none

module svss_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [svss_pkg::ANGLE_W-1:0]    angle,
    input wire logic [svss_pkg::PHASE_W-1:0]    phase
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(angle) && $stable(phase))
        else $error("stalled result changed");

    // The block works on one tick at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // Every tick takes its sequencer pass before the next one enters.
    a_min_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 in_stall)
        else $error("request taken before the previous one finished");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase <= svss_pkg::PH_LOW))
        else $error("phase code out of range");

endmodule

bind servo_sweep_sequencer_top svss_checker u_svss_checker (.*);

`default_nettype wire
